/* rtl/two_string_deletion_distance_top_defines.svh */
// Assertion macros used by the core RTL file.
`ifndef TWO_STRING_DELETION_DISTANCE_TOP_DEFINES_SVH
`define TWO_STRING_DELETION_DISTANCE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/tsdd_pkg.sv */
`default_nettype none

package tsdd_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int FUNC_W      = 2;
    localparam int CHAR_W      = 8;
    localparam int DIST_W      = 8;

    localparam logic [FUNC_W-1:0] FUNC_LOAD_FIRST  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_SECOND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE     = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } stat_t;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

`default_nettype wire

/* rtl/tsdd_core.sv */
`default_nettype none

module tsdd_core #(
    parameter int MAX_LEN = tsdd_pkg::MAX_LEN_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     start,
    input  wire logic [$clog2(MAX_LEN+1)-1:0]             n1,
    input  wire logic [$clog2(MAX_LEN+1)-1:0]             n2,
    output logic      [tsdd_pkg::addr_w(MAX_LEN)-1:0]     first_addr,
    output logic      [tsdd_pkg::addr_w(MAX_LEN)-1:0]     second_addr,
    input  wire logic [tsdd_pkg::CHAR_W-1:0]              first_q,
    input  wire logic [tsdd_pkg::CHAR_W-1:0]              second_q,
    output tsdd_pkg::stat_t                               stat,
    output logic      [tsdd_pkg::DIST_W-1:0]              distance
);

    `include "two_string_deletion_distance_top_defines.svh"

    localparam int AW = tsdd_pkg::addr_w(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = $clog2(2 * MAX_LEN + 1);
    localparam int DW = (CW > tsdd_pkg::DIST_W) ? CW : tsdd_pkg::DIST_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROW   = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [LW-1:0] n1_reg, n1_next;
    logic [LW-1:0] n2_reg, n2_next;
    logic [AW-1:0] row_reg, row_next;
    logic [AW-1:0] col_reg, col_next;
    logic [CW-1:0] right_reg, right_next;
    logic [CW-1:0] diag_reg, diag_next;
    logic          done_reg, done_next;
    logic [tsdd_pkg::DIST_W-1:0] dist_reg, dist_next;

    logic [CW-1:0] cost_mem [MAX_LEN];
    logic [CW-1:0] cost_q;
    logic [AW-1:0] rd_addr;
    logic          cost_we;
    logic [CW-1:0] cost_wd;

    logic [LW-1:0] n2_m1;
    logic [LW-1:0] n1_m1;
    logic          first_row;
    logic [CW-1:0] below;
    logic [CW-1:0] best;
    logic [CW-1:0] cost_new;
    logic [DW-1:0] sat_in;
    logic [tsdd_pkg::DIST_W-1:0] sat_out;

    assign n2_m1     = n2_reg - 1'b1;
    assign n1_m1     = n1_reg - 1'b1;
    assign first_row = (row_reg == n1_m1[AW-1:0]);

    assign rd_addr     = (state_reg == ST_ROW) ? n2_m1[AW-1:0]
                       : ((col_reg == '0) ? '0 : col_reg - 1'b1);
    assign first_addr  = row_reg;
    assign second_addr = rd_addr;

    assign below    = first_row ? CW'(n2_reg - LW'(col_reg)) : cost_q;
    assign best     = (below < right_reg) ? below : right_reg;
    assign cost_new = (first_q == second_q) ? diag_reg : best + 1'b1;

    assign cost_we = (state_reg == ST_SWEEP);
    assign cost_wd = cost_new;

    always_comb
    begin
        sat_in = DW'(cost_new);
        if (state_reg == ST_IDLE)
        begin
            sat_in = DW'(CW'(n1) + CW'(n2));
        end
        sat_out = (sat_in > DW'(255)) ? 8'hFF : sat_in[tsdd_pkg::DIST_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cost_we)
        begin
            cost_mem[col_reg] <= cost_wd;
        end
        cost_q <= cost_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        n1_next    = n1_reg;
        n2_next    = n2_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        right_next = right_reg;
        diag_next  = diag_reg;
        done_next  = 1'b0;
        dist_next  = dist_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n1_next = n1;
                    n2_next = n2;
                    if (n1 == '0 || n2 == '0)
                    begin
                        done_next = 1'b1;
                        dist_next = sat_out;
                    end
                    else
                    begin
                        row_next   = AW'(n1 - 1'b1);
                        state_next = ST_ROW;
                    end
                end
            end
            ST_ROW:
            begin
                col_next   = n2_m1[AW-1:0];
                right_next = CW'(n1_reg) - CW'(row_reg);
                diag_next  = CW'(n1_reg) - CW'(row_reg) - 1'b1;
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                right_next = cost_new;
                diag_next  = below;
                if (col_reg == '0)
                begin
                    if (row_reg == '0)
                    begin
                        done_next  = 1'b1;
                        dist_next  = sat_out;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg - 1'b1;
                        state_next = ST_ROW;
                    end
                end
                else
                begin
                    col_next = col_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n1_reg    <= n1_next;
        n2_reg    <= n2_next;
        row_reg   <= row_next;
        col_reg   <= col_next;
        right_reg <= right_next;
        diag_reg  <= diag_next;
        dist_reg  <= dist_next;
    end

    assign stat.busy = (state_reg != ST_IDLE) || done_reg;
    assign stat.done = done_reg;
    assign distance  = dist_reg;

    `ASSERT_IMPLIES(a_done_idle, clk, rst_n, done_reg, state_reg == ST_IDLE)
    `ASSERT_NEXT(a_row_to_sweep, clk, rst_n, state_reg == ST_ROW, state_reg == ST_SWEEP)
    `ASSERT_NEXT(a_col_step, clk, rst_n, state_reg == ST_SWEEP && col_reg != '0,
                 state_reg == ST_SWEEP && col_reg == $past(col_reg) - 1'b1)
    `ASSERT_IMPLIES(a_no_start_busy, clk, rst_n, stat.busy, !start)

endmodule

`default_nettype wire

/* rtl/two_string_deletion_distance_top.sv */
// Channel  Signals                         Payload
// -------  ------------------------------  ---------------------------------
// s_axis   tvalid tready tdata tuser       tdata: ch; tuser: func
// m_axis   tvalid tready tdata tuser       tdata: distance; tuser: overflow
//
// A compute item passes a row state, then sweeps the cost row memory once
// per first-string character, one cell per cycle; an empty string gives the
// result straight from idle. No item is taken while a compute runs.
// Reset clears both lengths, the dropped-character flag and the output valid flag.
// Loads are taken while a result waits; a compute waits for a free output slot.
`default_nettype none

module two_string_deletion_distance_top #(
    parameter int MAX_LEN = tsdd_pkg::MAX_LEN_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] ch
    input  wire logic [1:0] s_axis_tuser,   // [1:0] func
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic      [7:0] m_axis_tdata,   // [7:0] distance
    output logic            m_axis_tuser    // [0] overflow
);

    localparam int AW = tsdd_pkg::addr_w(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);

    logic [LW-1:0] first_len_reg, first_len_next;
    logic [LW-1:0] second_len_reg, second_len_next;
    logic          dropped_reg, dropped_next;
    logic          ovf_reg, ovf_next;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_data_reg, m_data_next;
    logic          m_user_reg, m_user_next;

    logic [tsdd_pkg::CHAR_W-1:0] first_mem  [MAX_LEN];
    logic [tsdd_pkg::CHAR_W-1:0] second_mem [MAX_LEN];
    logic [tsdd_pkg::CHAR_W-1:0] first_q;
    logic [tsdd_pkg::CHAR_W-1:0] second_q;
    logic [AW-1:0]               first_addr;
    logic [AW-1:0]               second_addr;
    logic                        first_we;
    logic                        second_we;

    logic                        accept;
    logic                        start;
    logic                        out_blocked;
    tsdd_pkg::stat_t             stat;
    logic [tsdd_pkg::DIST_W-1:0] distance;

    assign out_blocked   = m_valid_reg && !m_axis_tready;
    assign s_axis_tready = !stat.busy
                           && !(s_axis_tuser == tsdd_pkg::FUNC_COMPUTE && out_blocked);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign start         = accept && (s_axis_tuser == tsdd_pkg::FUNC_COMPUTE);

    assign first_we  = accept && (s_axis_tuser == tsdd_pkg::FUNC_LOAD_FIRST)
                       && (first_len_reg < LW'(MAX_LEN));
    assign second_we = accept && (s_axis_tuser == tsdd_pkg::FUNC_LOAD_SECOND)
                       && (second_len_reg < LW'(MAX_LEN));

    always_ff @(posedge clk)
    begin
        if (first_we)
        begin
            first_mem[first_len_reg[AW-1:0]] <= s_axis_tdata;
        end
        first_q <= first_mem[first_addr];
    end

    always_ff @(posedge clk)
    begin
        if (second_we)
        begin
            second_mem[second_len_reg[AW-1:0]] <= s_axis_tdata;
        end
        second_q <= second_mem[second_addr];
    end

    always_comb
    begin
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        dropped_next    = dropped_reg;
        ovf_next        = ovf_reg;
        if (accept)
        begin
            unique case (s_axis_tuser)
                tsdd_pkg::FUNC_LOAD_FIRST:
                begin
                    if (first_we)
                    begin
                        first_len_next = first_len_reg + 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
                tsdd_pkg::FUNC_LOAD_SECOND:
                begin
                    if (second_we)
                    begin
                        second_len_next = second_len_reg + 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
                tsdd_pkg::FUNC_COMPUTE:
                begin
                    ovf_next        = dropped_reg;
                    first_len_next  = '0;
                    second_len_next = '0;
                    dropped_next    = 1'b0;
                end
                default:
                begin
                    dropped_next = dropped_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (stat.done)
        begin
            m_valid_next = 1'b1;
            m_data_next  = distance;
            m_user_next  = ovf_reg;
        end
        else if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_len_reg  <= '0;
            second_len_reg <= '0;
            dropped_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            dropped_reg    <= dropped_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg    <= ovf_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    tsdd_core #(
        .MAX_LEN (MAX_LEN)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .n1          (first_len_reg),
        .n2          (second_len_reg),
        .first_addr  (first_addr),
        .second_addr (second_addr),
        .first_q     (first_q),
        .second_q    (second_q),
        .stat        (stat),
        .distance    (distance)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

`default_nettype wire

/* verif/tb_two_string_deletion_distance_top.sv */
`timescale 1ns / 100ps

module tb_two_string_deletion_distance_top;

    localparam int FUNC_W = tsdd_pkg::FUNC_W;
    localparam int CHAR_W = tsdd_pkg::CHAR_W;
    localparam int DIST_W = tsdd_pkg::DIST_W;
    localparam int STR_CAP = tsdd_pkg::MAX_LEN_DEF;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 40000;
    localparam int PHASE_ITEMS = 350;
    localparam int TAIL_CYCLES = 100;

    typedef struct {
        logic [FUNC_W-1:0] op;
        logic [CHAR_W-1:0] ch;
        bit                settle;
    } char_req_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;
    logic [1:0] s_axis_tuser = 2'd0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic m_axis_tuser;

    char_req_t pending_q[$];
    verdict_t verdict_q[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int queued_items = 0;
    int errors = 0;
    int quiet = 0;

    logic [CHAR_W-1:0] first_str[STR_CAP];
    logic [CHAR_W-1:0] second_str[STR_CAP];
    int first_cnt = 0;
    int second_cnt = 0;
    bit lost_chars = 1'b0;

    two_string_deletion_distance_top #(
        .MAX_LEN(STR_CAP)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic logic [DIST_W-1:0] deletion_cost();
        int unsigned row[STR_CAP + 1];
        int unsigned diag;
        int unsigned below;
        int unsigned right;
        int unsigned cost_new;
        int r;
        int c;
        for (int j = 0; j <= second_cnt; j++)
            row[j] = second_cnt - j;
        for (int i = first_cnt; i > 0; i--)
        begin
            r = i - 1;
            diag = row[second_cnt];
            row[second_cnt] = first_cnt - r;
            for (int j = second_cnt; j > 0; j--)
            begin
                c = j - 1;
                below = row[c];
                if (first_str[r] == second_str[c])
                    cost_new = diag;
                else
                begin
                    right = row[c + 1];
                    cost_new = 1 + ((below < right) ? below : right);
                end
                row[c] = cost_new;
                diag = below;
            end
        end
        return (row[0] > 255) ? 8'd255 : row[0][7:0];
    endfunction

    task automatic absorb_item(input logic [FUNC_W-1:0] op,
                               input logic [CHAR_W-1:0] ch);
        verdict_t v;
        case (op)
            tsdd_pkg::FUNC_LOAD_FIRST:
                if (first_cnt < STR_CAP)
                begin
                    first_str[first_cnt] = ch;
                    first_cnt++;
                end
                else
                    lost_chars = 1'b1;
            tsdd_pkg::FUNC_LOAD_SECOND:
                if (second_cnt < STR_CAP)
                begin
                    second_str[second_cnt] = ch;
                    second_cnt++;
                end
                else
                    lost_chars = 1'b1;
            tsdd_pkg::FUNC_COMPUTE:
            begin
                v.distance = deletion_cost();
                v.overflow = lost_chars;
                verdict_q.push_back(v);
                first_cnt = 0;
                second_cnt = 0;
                lost_chars = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic push_req(input logic [FUNC_W-1:0] op, input logic [CHAR_W-1:0] ch,
                            input bit settle);
        char_req_t r;
        r.op = op;
        r.ch = ch;
        r.settle = settle;
        pending_q.push_back(r);
        if (op != FUNC_UNUSED)
            queued_items++;
    endtask

    function automatic logic [CHAR_W-1:0] pick_char(input bit wide);
        return wide ? CHAR_W'($urandom_range(255)) : CHAR_W'(8'h61 + $urandom_range(3));
    endfunction

    task automatic queue_pair();
        logic [CHAR_W-1:0] word_a[$];
        logic [CHAR_W-1:0] word_b[$];
        int len_a;
        int len_b;
        int swap;
        int pick;
        int ia;
        int ib;
        bit wide;
        bit hold;
        pick = $urandom_range(99);
        wide = ($urandom_range(3) == 0);
        if (pick < 4)
        begin
            len_a = STR_CAP + $urandom_range(1, 6);
            len_b = $urandom_range(STR_CAP);
            if ($urandom_range(1) == 1)
            begin
                swap = len_a;
                len_a = len_b;
                len_b = swap;
            end
        end
        else if (pick < 12)
        begin
            len_a = $urandom_range(20, STR_CAP);
            len_b = $urandom_range(20, STR_CAP);
        end
        else
        begin
            len_a = $urandom_range(12);
            len_b = $urandom_range(12);
        end
        for (int k = 0; k < len_a; k++)
            word_a.push_back(pick_char(wide));
        for (int k = 0; k < len_b; k++)
            if ($urandom_range(2) != 0 && k < len_a)
                word_b.push_back(word_a[(k + 1 < len_a && $urandom_range(3) == 0) ? k + 1 : k]);
            else
                word_b.push_back(pick_char(wide));
        hold = ($urandom_range(9) == 0);
        ia = 0;
        ib = 0;
        while (ia < len_a || ib < len_b)
        begin
            if ($urandom_range(29) == 0)
            begin
                push_req(FUNC_UNUSED, CHAR_W'($urandom_range(255)), hold);
                hold = 1'b0;
            end
            if (ib >= len_b || (ia < len_a && $urandom_range(1) == 0))
            begin
                push_req(tsdd_pkg::FUNC_LOAD_FIRST, word_a[ia], hold);
                ia++;
            end
            else
            begin
                push_req(tsdd_pkg::FUNC_LOAD_SECOND, word_b[ib], hold);
                ib++;
            end
            hold = 1'b0;
        end
        push_req(tsdd_pkg::FUNC_COMPUTE, CHAR_W'($urandom_range(255)), hold);
        if ($urandom_range(19) == 0)
            push_req(tsdd_pkg::FUNC_COMPUTE, CHAR_W'($urandom_range(255)), 1'b0);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : drive_proc
        char_req_t nxt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'd0;
            s_axis_tuser <= 2'd0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct
                && !(pending_q[0].settle && (s_axis_tvalid || verdict_q.size() != 0)))
            begin
                nxt = pending_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= nxt.ch;
                s_axis_tuser <= nxt.op;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : observe_proc
        verdict_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: extra item, expected none, actual distance %0d overflow %0d",
                             $time, m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (m_axis_tdata !== want.distance)
                    begin
                        errors++;
                        $display("%0t: distance mismatch, expected %0d, actual %0d",
                                 $time, want.distance, m_axis_tdata);
                    end
                    if (m_axis_tuser !== want.overflow)
                    begin
                        errors++;
                        $display("%0t: overflow mismatch, expected %0d, actual %0d",
                                 $time, want.overflow, m_axis_tuser);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                absorb_item(s_axis_tuser, s_axis_tdata);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        int target;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        push_req(tsdd_pkg::FUNC_COMPUTE, 8'h00, 1'b0);
        push_req(tsdd_pkg::FUNC_LOAD_FIRST, 8'h00, 1'b0);
        push_req(tsdd_pkg::FUNC_LOAD_FIRST, 8'hFF, 1'b0);
        push_req(tsdd_pkg::FUNC_COMPUTE, 8'hFF, 1'b0);
        push_req(tsdd_pkg::FUNC_LOAD_SECOND, 8'hFF, 1'b0);
        push_req(tsdd_pkg::FUNC_COMPUTE, 8'h00, 1'b0);
        push_req(FUNC_UNUSED, 8'hAA, 1'b0);
        push_req(FUNC_UNUSED, 8'h55, 1'b0);
        push_req(tsdd_pkg::FUNC_COMPUTE, 8'h00, 1'b0);
        push_req(tsdd_pkg::FUNC_LOAD_FIRST, 8'h00, 1'b0);
        push_req(tsdd_pkg::FUNC_LOAD_SECOND, 8'h80, 1'b0);
        push_req(tsdd_pkg::FUNC_LOAD_FIRST, 8'h80, 1'b0);
        push_req(tsdd_pkg::FUNC_LOAD_SECOND, 8'hFF, 1'b0);
        push_req(tsdd_pkg::FUNC_LOAD_FIRST, 8'hFF, 1'b0);
        push_req(tsdd_pkg::FUNC_LOAD_SECOND, 8'h01, 1'b0);
        push_req(tsdd_pkg::FUNC_COMPUTE, 8'h00, 1'b0);
        push_req(tsdd_pkg::FUNC_LOAD_FIRST, 8'h61, 1'b1);
        push_req(tsdd_pkg::FUNC_LOAD_FIRST, 8'h62, 1'b0);
        push_req(tsdd_pkg::FUNC_LOAD_SECOND, 8'h61, 1'b0);
        push_req(tsdd_pkg::FUNC_LOAD_SECOND, 8'h62, 1'b0);
        push_req(tsdd_pkg::FUNC_COMPUTE, 8'h00, 1'b0);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 68;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 68;
                end
                default:
                begin
                    send_idle_pct = 18;
                    recv_stall_pct = 18;
                end
            endcase
            target = queued_items + PHASE_ITEMS;
            while (queued_items < target)
                queue_pair();
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
